/* rtl/core/gle_pkg.sv */
// Shared widths, types and helper functions for the GIF LZW encoder.
package gle_pkg;

	localparam int PIX_W  = 8;
	localparam int CODE_W = 12;
	localparam int M_W    = 4;
	localparam int NFC_W  = 13;

	localparam logic [M_W-1:0] M_MIN   = 4'd2;
	localparam logic [M_W-1:0] M_MAX   = 4'd8;
	localparam logic [M_W-1:0] M_RESET = 4'd8;

	// One learned dictionary entry: prefix code and suffix pixel.
	typedef struct packed {
		logic [CODE_W-1:0] prefix;
		logic [PIX_W-1:0]  suffix;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PROBE_WAIT,
		S_SLOT_CHK,
		S_ENT_CMP,
		S_EMIT_CLEAR,
		S_EMIT_MISS,
		S_EMIT_FLUSH,
		S_EMIT_END
	} state_t;

	// Bring a programmed width into the legal range of two to eight bits.
	function automatic logic [M_W-1:0] clamp_width(input logic [M_W-1:0] m);
		if (m < M_MIN) begin
			return M_MIN;
		end else if (m > M_MAX) begin
			return M_MAX;
		end
		return m;
	endfunction

	// Mask that keeps the low m bits of a pixel index.
	function automatic logic [PIX_W-1:0] pix_mask(input logic [M_W-1:0] m);
		logic [PIX_W:0] t;
		t = (PIX_W+1)'(1) << m;
		return PIX_W'(t - (PIX_W+1)'(1));
	endfunction

	// First learned code of a stream: two above the clear code.
	function automatic logic [NFC_W-1:0] first_free(input logic [M_W-1:0] m);
		return (NFC_W'(1) << m) + NFC_W'(2);
	endfunction

endpackage

/* rtl/core/gle_if.sv */
// Channel interfaces of the GIF LZW encoder: pixels in, codes out, width register write.
interface gle_pix_if import gle_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	logic             first_item;
	logic             last_item;

	modport source (output valid, output pixel, output first_item, output last_item,
		input ready);
	modport sink (input valid, input pixel, input first_item, input last_item,
		output ready);
endinterface

interface gle_code_if import gle_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] code;
	logic              end_of_stream;

	modport source (output valid, output code, output end_of_stream, input ready);
	modport sink (input valid, input code, input end_of_stream, output ready);
endinterface

interface gle_cfg_if import gle_pkg::*; ();
	logic           valid;
	logic           ready;
	logic [M_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/gif_lzw_encoder.sv */
// GIF-style LZW encoder top level: hashed dictionary search, sequencer and output register.
//
// Pixels arrive one per transfer on pix and leave as whole 12-bit LZW codes on codes; the
// clear code opens each stream (first_item) and the final code plus the end code close it
// (last_item, end_of_stream set on the end code). cfg writes min_code_size, which is taken
// up at the next first_item. The dictionary is found through a linear-probed hash table of
// twice TABLE_ENTRIES slots, each slot holding a code that points into the entry memory,
// and each learned entry records the slot it was placed in. A slot is live only when its
// code lies between the stream's first learned code and the next free code and the entry
// it names records that slot; anything else reads as empty, so neither memory is cleared
// after reset or between streams. A probe reads the slot and checks its code's range, and
// when the code is in range reads the entry and compares it with the pair being searched.
// An item costs its transfer, its probes and one emit per code, each emit waiting while
// the output register is full. A live slot whose entry differs from the pair but records
// that slot sends the search on to the next slot. A last item adds the emit of the final
// code and of the end code; a first item emits the clear code and probes nothing. The
// block takes a new pixel while its last code still waits in the output register.
module gif_lzw_encoder
	import gle_pkg::*;
#(
	parameter int TABLE_ENTRIES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	gle_pix_if.sink     pix,
	gle_code_if.source  codes,
	gle_cfg_if.sink     cfg
);

	localparam int EW     = $clog2(TABLE_ENTRIES);
	localparam int HW     = EW + 1;
	localparam int HDEPTH = 2 ** HW;
	localparam logic [NFC_W-1:0] FULL_MARK = NFC_W'(TABLE_ENTRIES);

	state_t state_q, state_d;

	logic [M_W-1:0]    min_code_size_q;
	logic [M_W-1:0]    active_m_q;
	logic [NFC_W-1:0]  nfc_q;
	logic [CODE_W-1:0] cur_q;
	logic [PIX_W-1:0]  pix_q;
	logic              last_q;
	logic [HW-1:0]     hash_idx_q;

	logic [CODE_W-1:0] slot_q;
	entry_t            ent_q;
	logic [HW-1:0]     home_q;
	logic [CODE_W-1:0] hash_mem [HDEPTH];
	entry_t            entry_mem [TABLE_ENTRIES];
	logic [HW-1:0]     home_mem [TABLE_ENTRIES];

	logic              out_valid_q;
	logic [CODE_W-1:0] out_code_q;
	logic              out_eos_q;

	logic              take;
	logic              emit_ok;
	logic              load;
	logic [CODE_W-1:0] load_code;
	logic              load_eos;
	logic              ins_we;
	logic              in_range;
	logic              match;
	logic              owned;
	logic [M_W-1:0]    m_new;
	logic [M_W-1:0]    m_use;
	logic [PIX_W-1:0]  pix_in;
	logic [NFC_W-1:0]  base;
	logic [HW-1:0]     hash_new;

	// Input side decode and the hash of the pair being searched.
	assign take     = pix.valid && pix.ready;
	assign m_new    = clamp_width(min_code_size_q);
	assign m_use    = pix.first_item ? m_new : active_m_q;
	assign pix_in   = pix.pixel & pix_mask(m_use);
	assign hash_new = HW'(cur_q) ^ (HW'(pix_in) << (HW - PIX_W));
	assign base     = first_free(active_m_q);

	// Probe comparator: slot range check, then the stored pair against the search pair.
	// A slot belongs to its entry only when that entry was placed in this very slot.
	assign in_range = (NFC_W'(slot_q) >= base) && (NFC_W'(slot_q) < nfc_q);
	assign match    = (ent_q.prefix == cur_q) && (ent_q.suffix == pix_q);
	assign owned    = (home_q == hash_idx_q);

	// The output register is free when empty or being drained in this cycle.
	assign emit_ok = !out_valid_q || codes.ready;

	assign pix.ready     = (state_q == S_IDLE);
	assign cfg.ready     = 1'b1;
	assign codes.valid   = out_valid_q;
	assign codes.code    = out_code_q;
	assign codes.end_of_stream = out_eos_q;

	// Sequencer: next state and the code to be loaded into the output register.
	always_comb begin
		state_d   = state_q;
		load      = 1'b0;
		load_code = cur_q;
		load_eos  = 1'b0;
		ins_we    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					state_d = pix.first_item ? S_EMIT_CLEAR : S_PROBE_WAIT;
				end
			end
			S_PROBE_WAIT: begin
				state_d = S_SLOT_CHK;
			end
			S_SLOT_CHK: begin
				if (in_range) begin
					state_d = S_ENT_CMP;
				end else begin
					state_d = S_EMIT_MISS;
				end
			end
			S_ENT_CMP: begin
				if (match) begin
					state_d = last_q ? S_EMIT_FLUSH : S_IDLE;
				end else if (owned) begin
					state_d = S_PROBE_WAIT;
				end else begin
					state_d = S_EMIT_MISS;
				end
			end
			S_EMIT_CLEAR: begin
				if (emit_ok) begin
					load      = 1'b1;
					load_code = CODE_W'(base - NFC_W'(2));
					state_d   = last_q ? S_EMIT_FLUSH : S_IDLE;
				end
			end
			S_EMIT_MISS: begin
				if (emit_ok) begin
					load    = 1'b1;
					ins_we  = (nfc_q < FULL_MARK);
					state_d = last_q ? S_EMIT_FLUSH : S_IDLE;
				end
			end
			S_EMIT_FLUSH: begin
				if (emit_ok) begin
					load    = 1'b1;
					state_d = S_EMIT_END;
				end
			end
			S_EMIT_END: begin
				if (emit_ok) begin
					load      = 1'b1;
					load_code = CODE_W'(base - NFC_W'(1));
					load_eos  = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Width register, written by a cfg transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_code_size_q <= M_RESET;
		end else if (cfg.valid && cfg.ready) begin
			min_code_size_q <= cfg.data;
		end
	end

	// Stream state: active width, next free code and the current string's code.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_m_q <= M_RESET;
			nfc_q      <= first_free(M_RESET);
			cur_q      <= '0;
		end else begin
			if (take && pix.first_item) begin
				active_m_q <= m_new;
				nfc_q      <= first_free(m_new);
			end
			if (ins_we) begin
				nfc_q <= nfc_q + NFC_W'(1);
			end
			if (state_q == S_ENT_CMP && match) begin
				cur_q <= slot_q;
			end
			if (load && (state_q == S_EMIT_CLEAR || state_q == S_EMIT_MISS)) begin
				cur_q <= CODE_W'(pix_q);
			end
		end
	end

	// Item and probe registers; payload only, no reset needed.
	always_ff @(posedge clk) begin
		if (take) begin
			pix_q      <= pix_in;
			last_q     <= pix.last_item;
			hash_idx_q <= hash_new;
		end else if (state_q == S_ENT_CMP && !match && owned) begin
			hash_idx_q <= hash_idx_q + HW'(1);
		end
	end

	// Hash slots, learned entries and their home slots; reads are registered every cycle.
	always_ff @(posedge clk) begin
		if (ins_we) begin
			hash_mem[hash_idx_q]       <= CODE_W'(nfc_q);
			entry_mem[nfc_q[EW-1:0]]   <= '{prefix: cur_q, suffix: pix_q};
			home_mem[nfc_q[EW-1:0]]    <= hash_idx_q;
		end
		slot_q <= hash_mem[hash_idx_q];
		ent_q  <= entry_mem[slot_q[EW-1:0]];
		home_q <= home_mem[slot_q[EW-1:0]];
	end

	// Output register: holds one code until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (codes.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_code_q <= load_code;
			out_eos_q  <= load_eos;
		end
	end

	// The next free code never runs past the end of the table.
	a_nfc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nfc_q <= FULL_MARK)
		else $error("next free code beyond table");

	// Between items the current string names a root or an entry already learned.
	a_cur_known: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (NFC_W'(cur_q) < nfc_q))
		else $error("current code not yet defined");

	// A hit is only taken from a slot that passed the range check.
	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ENT_CMP) |-> in_range)
		else $error("entry compare on a slot outside the live range");

	// The end code closes the item and the block is ready for the next stream.
	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load && load_eos) |=> (state_q == S_IDLE))
		else $error("sequencer did not return to idle after the end code");

endmodule
